// ===== rtl/ipban_pkg.sv =====
// ipban_pkg: shared types, command and status codes for the ip ban table
// used by every module under rtl; depends on nothing
package ipban_pkg;

   localparam int DEFAULT_MAX_RULES = 16;

   // command codes
   localparam logic [1:0] CMD_CHECK  = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   // status codes
   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] address;
      logic [31:0] net_mask;
      logic [31:0] expiry;
      logic [31:0] now_seconds;
      logic [4:0]  position;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] status;
      logic [4:0] rule_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] address;
      logic [31:0] mask;
      logic [31:0] expiry;
   } rule_type;

   typedef struct packed {
      logic ban_hit;
      logic same_rule;
   } match_type;

endpackage

// ===== rtl/ipban_rule_mem.sv =====
// ipban_rule_mem: rule storage, one write port and one registered read port
// depends on ipban_pkg for rule_type
module ipban_rule_mem
   import ipban_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_RULES,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  rule_type         wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   output rule_type         rd_data
);

   rule_type mem [DEPTH];
   rule_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ipban_rule_match.sv =====
// ipban_rule_match: compares one stored rule against the current transaction
// depends on ipban_pkg for rule_type and match_type
module ipban_rule_match
   import ipban_pkg::*;
(
   input  rule_type    rule,
   input  logic [31:0] address,
   input  logic [31:0] net_mask,
   input  logic [31:0] now_seconds,
   output match_type   result
);

   logic addr_eq;
   logic live;

   assign addr_eq = (rule.address & rule.mask) == (address & rule.mask);
   // permanent rule or not yet expired
   assign live    = (rule.expiry == 32'd0) || (now_seconds < rule.expiry);

   assign result.ban_hit   = addr_eq && live;
   assign result.same_rule = (rule.address == address) && (rule.mask == net_mask);

endmodule

// ===== rtl/masked_ip_ban_table_core.sv =====
// masked_ip_ban_table_core: top level of the ordered ip ban rule table
// depends on ipban_pkg, ipban_rule_mem and ipban_rule_match
//
// usage:
//   req channel (req_valid / req_stall / req_data) carries one command per
//   transaction: check an address, add or update a rule, or remove a rule by
//   1-based position. rsp channel (rsp_valid / rsp_stall / rsp_data) returns
//   exactly one result per command, in order.
// timing:
//   one command at a time. check and add walk the stored rules through the
//   rule memory read port, one rule per cycle, and stop early when a rule
//   matches. remove copies each later rule one slot down over the same
//   read and write ports. a check of address zero, a bad position or an
//   unknown command skips the walk and goes straight to the result.
// reset:
//   synchronous, active high; empties the table (rule count to zero) and
//   clears the response valid flag. rule memory itself is not cleared.
// stall:
//   the response sits in an output register; a new command is taken while
//   it waits. a finished result holds the block until the register frees.
module masked_ip_ban_table_core
   import ipban_pkg::*;
#(
   parameter int MAX_RULES = DEFAULT_MAX_RULES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CNT_W = $clog2(MAX_RULES + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             eval_vld_ff, eval_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   req_type          item_ff, item_in;
   logic [IDX_W-1:0] eval_idx_ff, eval_idx_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // memory and compare wiring
   logic             rd_en, wr_en;
   logic [IDX_W-1:0] wr_idx;
   rule_type         wr_data, rd_data;
   match_type        match;

   logic [CMP_W-1:0] pos_w, used_w;
   logic             scan_more;
   logic             rsp_free;

   function automatic logic [4:0] to_count(input logic [CNT_W-1:0] n);
      logic [CMP_W-1:0] w;
      w = CMP_W'(n);
      return w[4:0];
   endfunction

   ipban_rule_mem #(
      .DEPTH (MAX_RULES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   ipban_rule_match u_match (
      .rule        (rd_data),
      .address     (item_ff.address),
      .net_mask    (item_ff.net_mask),
      .now_seconds (item_ff.now_seconds),
      .result      (match)
   );

   assign pos_w     = CMP_W'(req_data.position);
   assign used_w    = CMP_W'(used_ff);
   assign scan_more = rd_idx_ff < used_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rd_idx_ff    <= '0;
         eval_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rd_idx_ff    <= rd_idx_in;
         eval_vld_ff  <= eval_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      eval_idx_ff <= eval_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      rd_idx_in    = rd_idx_ff;
      eval_vld_in  = 1'b0;
      eval_idx_in  = eval_idx_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = eval_idx_ff;
      wr_data      = '{address: item_ff.address, mask: item_ff.net_mask,
                       expiry: item_ff.expiry};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in   = req_data;
               // remove starts copying from the slot just after the erased one
               rd_idx_in = (req_data.command == CMD_REMOVE) ?
                           pos_w[CNT_W-1:0] : '0;
               res_in    = '{hit: 1'b0, status: STAT_DONE,
                             rule_count: to_count(used_ff)};
               case (req_data.command)
                  CMD_CHECK: begin
                     // address zero is never banned
                     state_in = (req_data.address == 32'd0) ? ST_DONE : ST_SCAN;
                  end
                  CMD_ADD: begin
                     state_in = ST_SCAN;
                  end
                  CMD_REMOVE: begin
                     if ((pos_w == '0) || (pos_w > used_w)) begin
                        res_in.status = STAT_RANGE;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // read side of the pipeline: one rule per cycle
            if (scan_more) begin
               rd_en       = 1'b1;
               eval_vld_in = 1'b1;
               eval_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
            end
            // evaluate side: rule read in the previous cycle
            case (item_ff.command)
               CMD_CHECK: begin
                  if (eval_vld_ff && match.ban_hit) begin
                     res_in.hit = 1'b1;
                     state_in   = ST_DONE;
                  end else if (!eval_vld_ff && !scan_more) begin
                     state_in = ST_DONE;
                  end
               end
               CMD_ADD: begin
                  if (eval_vld_ff && match.same_rule) begin
                     // same address and mask: only the expiry changes
                     wr_en      = 1'b1;
                     wr_idx     = eval_idx_ff;
                     res_in.hit = 1'b1;
                     state_in   = ST_DONE;
                  end else if (!eval_vld_ff && !scan_more) begin
                     if (used_ff < CNT_W'(MAX_RULES)) begin
                        // append at the end of the table
                        wr_en             = 1'b1;
                        wr_idx            = used_ff[IDX_W-1:0];
                        used_in           = used_ff + CNT_W'(1);
                        res_in.rule_count = to_count(used_ff + CNT_W'(1));
                     end else begin
                        res_in.status = STAT_FULL;
                     end
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  // remove: move each later rule one slot down
                  if (eval_vld_ff) begin
                     wr_en   = 1'b1;
                     wr_idx  = eval_idx_ff - IDX_W'(1);
                     wr_data = rd_data;
                  end else if (!scan_more) begin
                     used_in           = used_ff - CNT_W'(1);
                     res_in.hit        = 1'b1;
                     res_in.rule_count = to_count(used_ff - CNT_W'(1));
                     state_in          = ST_DONE;
                  end
               end
            endcase
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   // rule count never passes table depth
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(MAX_RULES))
      else $error("rule count above table depth");

   // remove copy never reads and writes one slot in the same cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_idx != rd_idx_ff[IDX_W-1:0]))
      else $error("rule memory read and write to the same slot");

   // an accepted transaction always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted transaction left block idle");

   // a finished result reaches the output register once it is free
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("finished result not presented");

   // rule count only moves while a scan finishes
   a_used_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |=> $stable(used_ff))
      else $error("rule count changed outside a scan");
`endif

endmodule
